[sv/htlp_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the hash table.
package htlp_pkg;

    localparam int KEY_W          = 34;
    localparam int NAME_W         = 64;
    localparam int CMD_W          = 2;
    localparam int STAT_W         = 3;
    localparam int IN_W           = ((KEY_W + NAME_W + 7) / 8) * 8;
    localparam int TABLE_SIZE_DEF = 16;
    // key bits folded into the home-slot remainder per cycle
    localparam int MOD_DIG        = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the input item
        logic put_home;    // write new entry at home slot, result inserted at home
        logic probe_init;  // start the empty-slot probe after home
        logic probe_step;  // advance the probe
        logic move_res;    // move the resident of home to the probed slot
        logic place_new;   // write new entry at the probed slot
        logic res_full;    // result: table full
        logic scan_step;   // issue the next lookup read
        logic scan_hit;    // result: found or deleted at compared slot
        logic res_none;    // result: not found
        logic out_load;    // move the result into the output register
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_insert;
        logic in_lookup;
        logic mod_done;
        logic home_valid;
        logic probe_empty;
        logic probe_last;
        logic res_away;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_ctl_stat;

endpackage

[sv/htlp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module htlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/htlp_mod.sv]
// Iterative key-modulo-table-size unit, MOD_DIG key bits per cycle, most significant first.
module htlp_mod #(
    parameter int TABLE_SIZE = htlp_pkg::TABLE_SIZE_DEF,
    localparam int IW = $clog2(TABLE_SIZE)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [htlp_pkg::KEY_W-1:0] i_key,
    output logic                     o_done,
    output logic [IW-1:0]            o_rem
);

    import htlp_pkg::*;

    localparam int STEPS = (KEY_W + MOD_DIG - 1) / MOD_DIG;
    localparam int SH_W  = STEPS * MOD_DIG;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int WW    = IW + MOD_DIG;

    logic [SH_W-1:0] r_sh;
    logic [IW-1:0]   r_rem;
    logic [IW-1:0]   n_rem;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    // rem*2^DIG + digit is below 16*N: restoring subtract of 8N, 4N, 2N, N
    always_comb begin : p_reduce
        logic [WW-1:0] acc;
        acc = {r_rem, r_sh[SH_W-1 -: MOD_DIG]};
        for (int k = MOD_DIG - 1; k >= 0; k--) begin
            if (acc >= (WW'(TABLE_SIZE) << k)) begin
                acc = acc - (WW'(TABLE_SIZE) << k);
            end
        end
        n_rem = acc[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= SH_W'(i_key);
            r_rem <= '0;
            r_cnt <= CW'(STEPS);
        end else if (r_busy) begin
            r_sh  <= r_sh << MOD_DIG;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/htlp_dp.sv]
// Datapath: slot store, valid bits, probe and scan counters, result and output registers.
module htlp_dp #(
    parameter int TABLE_SIZE = htlp_pkg::TABLE_SIZE_DEF,
    localparam int IW = $clog2(TABLE_SIZE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [htlp_pkg::CMD_W-1:0]  i_in_cmd,
    input  logic [htlp_pkg::KEY_W-1:0]  i_in_key,
    input  logic [htlp_pkg::NAME_W-1:0] i_in_name,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [htlp_pkg::STAT_W-1:0] o_out_status,
    output logic [IW-1:0]               o_out_slot,
    output logic [htlp_pkg::NAME_W-1:0] o_out_name,
    input  htlp_pkg::t_ctl_cmd          i_cmd,
    output htlp_pkg::t_ctl_stat         o_stat
);

    import htlp_pkg::*;

    localparam int            WORD_W = KEY_W + IW + NAME_W;
    localparam logic [IW-1:0] LAST   = IW'(TABLE_SIZE - 1);

    logic [KEY_W-1:0]      r_key;
    logic [NAME_W-1:0]     r_name;
    logic                  r_is_find;
    logic [TABLE_SIZE-1:0] r_valid;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_cnt;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_cmp_vld;

    logic [STAT_W-1:0]     r_res_status, n_res_status;
    logic [IW-1:0]         r_res_slot, n_res_slot;
    logic [NAME_W-1:0]     r_res_name, n_res_name;

    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_out_status;
    logic [IW-1:0]         r_out_slot;
    logic [NAME_W-1:0]     r_out_name;

    logic                  in_insert;
    logic                  mod_done;
    logic [IW-1:0]         home;
    logic [IW-1:0]         home_next;
    logic [IW-1:0]         idx_next;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr;
    logic [WORD_W-1:0]     wr_data;
    logic [WORD_W-1:0]     rd_data;
    logic [KEY_W-1:0]      rd_key;
    logic [IW-1:0]         rd_home;
    logic [NAME_W-1:0]     rd_name;
    logic                  out_free;

    assign in_insert = (i_in_cmd == CMD_INSERT);

    htlp_mod #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load && in_insert),
        .i_key   (i_in_key),
        .o_done  (mod_done),
        .o_rem   (home)
    );

    // each word: key, its home slot, name
    htlp_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_key  = rd_data[KEY_W-1:0];
    assign rd_home = rd_data[KEY_W +: IW];
    assign rd_name = rd_data[KEY_W + IW +: NAME_W];

    assign home_next = (home == LAST) ? '0 : home + 1'b1;
    assign idx_next  = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    // outside the scan the read port sits on home, so the resident is ready during the probe
    assign rd_addr = i_cmd.scan_step ? r_idx : home;
    assign wr_en   = i_cmd.put_home || i_cmd.move_res || i_cmd.place_new;
    assign wr_addr = i_cmd.put_home ? home : r_idx;
    assign wr_data = i_cmd.move_res ? rd_data : {r_name, home, r_key};

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.in_insert   = in_insert;
        o_stat.in_lookup   = (i_in_cmd == CMD_FIND) || (i_in_cmd == CMD_DELETE);
        o_stat.mod_done    = mod_done;
        o_stat.home_valid  = r_valid[home];
        o_stat.probe_empty = !r_valid[r_idx];
        o_stat.probe_last  = (r_cnt == LAST);
        o_stat.res_away    = (rd_home != home);
        o_stat.scan_hit    = r_cmp_vld && r_valid[r_cmp_idx] && (rd_key == r_key);
        o_stat.scan_last   = r_cmp_vld && (r_cmp_idx == LAST);
        o_stat.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_in_key;
            r_name    <= i_in_name;
            r_is_find <= (i_in_cmd == CMD_FIND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.put_home) begin
                r_valid[home] <= 1'b1;
            end
            if (i_cmd.place_new || i_cmd.move_res) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.scan_hit && !r_is_find) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.probe_init) begin
            r_idx <= home_next;
            r_cnt <= IW'(1);
        end else if (i_cmd.probe_step || i_cmd.scan_step) begin
            r_idx <= idx_next;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.scan_step) begin
            r_cmp_idx <= r_idx;
        end
    end

    // compare stage sees the read address issued in the cycle before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cmp_vld <= 1'b1;
        end
    end

    always_comb begin
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_name   = r_res_name;
        priority if (i_cmd.put_home) begin
            n_res_status = ST_INSERTED;
            n_res_slot   = home;
            n_res_name   = '0;
        end else if (i_cmd.place_new) begin
            n_res_status = ST_INSERTED;
            n_res_slot   = r_idx;
            n_res_name   = '0;
        end else if (i_cmd.res_full) begin
            n_res_status = ST_FULL;
            n_res_slot   = '0;
            n_res_name   = '0;
        end else if (i_cmd.scan_hit) begin
            n_res_status = r_is_find ? ST_FOUND : ST_DELETED;
            n_res_slot   = r_cmp_idx;
            n_res_name   = r_is_find ? rd_name : '0;
        end else if (i_cmd.res_none) begin
            n_res_status = ST_NOT_FOUND;
            n_res_slot   = '0;
            n_res_name   = '0;
        end else begin
            n_res_status = r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_name   <= n_res_name;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_name   <= r_res_name;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;
    assign o_out_name   = r_out_name;

    a_place_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.place_new || i_cmd.move_res) |-> !r_valid[r_idx])
        else $error("placement into an occupied slot");

    a_probe_not_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.place_new || i_cmd.move_res) |-> (r_idx != home))
        else $error("probe wrapped back to the home slot");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_hit |-> (r_cmp_vld && r_valid[r_cmp_idx]))
        else $error("lookup hit on an empty slot");

    a_full_all_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_full |-> (&r_valid))
        else $error("table full reported with an empty slot");

endmodule

[sv/htlp_ctrl.sv]
// Controller state machine sequencing insert, find and delete over the datapath.
module htlp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  htlp_pkg::t_ctl_stat i_stat,
    output htlp_pkg::t_ctl_cmd  o_cmd
);

    import htlp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MOD   = 7'b0000010,
        S_HOME  = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_MOVE  = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    priority if (i_stat.in_insert) begin
                        n_state = S_MOD;
                    end else if (i_stat.in_lookup) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.res_none = 1'b1;
                        n_state        = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (!i_stat.home_valid) begin
                    o_cmd.put_home = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_PROBE;
                end
            end
            S_PROBE: begin
                priority if (i_stat.probe_empty) begin
                    // resident away from its own home gets pushed on, new key takes home
                    if (i_stat.res_away) begin
                        o_cmd.move_res = 1'b1;
                        n_state        = S_MOVE;
                    end else begin
                        o_cmd.place_new = 1'b1;
                        n_state         = S_DONE;
                    end
                end else if (i_stat.probe_last) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.probe_step = 1'b1;
                end
            end
            S_MOVE: begin
                o_cmd.put_home = 1'b1;
                n_state        = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                priority if (i_stat.scan_hit) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.scan_last) begin
                    o_cmd.res_none = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/hash_table_linear_probe_replace.sv]
// Linear-probing hash table with replacement: top level joining controller and datapath.
// Open-addressed table of TABLE_SIZE slots, each holding a 34-bit key and a 64-bit name;
// a key's home slot is key mod TABLE_SIZE. One item is worked on at a time; the result
// sits in an output register, so the next item is taken while it waits. An insert first
// folds the key into its home slot at 4 bits a cycle and writes the new entry at home when
// home is empty; else it probes one slot a cycle (up to TABLE_SIZE-1 slots) for an empty
// one and places the new entry there, or moves the resident on to it and puts the new key
// at home when the resident is away from its own home. Find and delete read the slot store
// one slot a cycle from slot 0 and stop at the first match. An unused command gives
// not-found. Valid bits are cleared by reset, so the block is ready once reset is released.
module hash_table_linear_probe_replace #(
    parameter int TABLE_SIZE = htlp_pkg::TABLE_SIZE_DEF,
    localparam int IW = $clog2(TABLE_SIZE),
    localparam int OUT_W = ((IW + htlp_pkg::NAME_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [htlp_pkg::IN_W-1:0]   s_axis_tdata,  // lookup_key, entry_name
    input  logic [htlp_pkg::CMD_W-1:0]  s_axis_tuser,  // command
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_W-1:0]            m_axis_tdata,  // slot_index, found_name
    output logic [htlp_pkg::STAT_W-1:0] m_axis_tuser   // status
);

    import htlp_pkg::*;

    t_ctl_cmd          cmd;
    t_ctl_stat         stat;
    logic [IW-1:0]     out_slot;
    logic [NAME_W-1:0] out_name;

    htlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    htlp_dp #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_cmd     (s_axis_tuser),
        .i_in_key     (s_axis_tdata[KEY_W-1:0]),
        .i_in_name    (s_axis_tdata[KEY_W +: NAME_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_slot   (out_slot),
        .o_out_name   (out_name),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );

    assign m_axis_tdata = OUT_W'({out_name, out_slot});

endmodule

[verif/hash_table_linear_probe_replace_test.sv]
// Self-checking testbench for the linear-probing hash table with replacement.
module hash_table_linear_probe_replace_test;
    import htlp_pkg::*;

    localparam int TABLE_SIZE  = TABLE_SIZE_DEF;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int OUT_W       = ((SLOT_W + NAME_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 60;
    localparam int POOL_SIZE   = 24;
    // command code with no operation behind it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [NAME_W-1:0]   name;
    } t_table_result;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;   // lookup_key, entry_name
    logic [CMD_W-1:0]    s_axis_tuser  = '0;   // command
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;         // slot_index, found_name
    logic [STAT_W-1:0]   m_axis_tuser;         // status

    // shadow copy of the table
    logic                tbl_valid [TABLE_SIZE];
    logic [KEY_W-1:0]    tbl_key   [TABLE_SIZE];
    logic [NAME_W-1:0]   tbl_name  [TABLE_SIZE];

    t_table_result       pending_results[$];
    int                  err_count       = 0;
    int                  idle_cycles     = 0;
    int                  sender_idle_pct = 0;
    int                  rcv_stall_pct   = 0;

    hash_table_linear_probe_replace #(.TABLE_SIZE(TABLE_SIZE)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow table and returns its result.
    function automatic t_table_result apply_table_op(input logic [CMD_W-1:0] cmd,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [NAME_W-1:0] name);
        t_table_result r;
        int            home;
        int            empty_slot;
        int            hit;
        int            s;
        r.status   = ST_NOT_FOUND;
        r.slot     = '0;
        r.name     = '0;
        home       = int'(key % TABLE_SIZE);
        empty_slot = -1;
        hit        = -1;
        case (cmd)
            CMD_INSERT: begin
                if (!tbl_valid[home]) begin
                    tbl_valid[home] = 1'b1;
                    tbl_key[home]   = key;
                    tbl_name[home]  = name;
                    r.status        = ST_INSERTED;
                    r.slot          = SLOT_W'(home);
                end else begin
                    for (int n = 1; n <= TABLE_SIZE; n++) begin
                        s = (home + n) % TABLE_SIZE;
                        if (empty_slot < 0 && !tbl_valid[s])
                            empty_slot = s;
                    end
                    if (empty_slot < 0) begin
                        r.status = ST_FULL;
                    end else if (int'(tbl_key[home] % TABLE_SIZE) != home) begin
                        // resident is displaced: it moves on, new key takes home
                        tbl_valid[empty_slot] = 1'b1;
                        tbl_key[empty_slot]   = tbl_key[home];
                        tbl_name[empty_slot]  = tbl_name[home];
                        tbl_key[home]         = key;
                        tbl_name[home]        = name;
                        r.status              = ST_INSERTED;
                        r.slot                = SLOT_W'(home);
                    end else begin
                        tbl_valid[empty_slot] = 1'b1;
                        tbl_key[empty_slot]   = key;
                        tbl_name[empty_slot]  = name;
                        r.status              = ST_INSERTED;
                        r.slot                = SLOT_W'(empty_slot);
                    end
                end
            end
            CMD_FIND, CMD_DELETE: begin
                for (int n = 0; n < TABLE_SIZE; n++)
                    if (hit < 0 && tbl_valid[n] && tbl_key[n] == key)
                        hit = n;
                if (hit >= 0) begin
                    r.slot = SLOT_W'(hit);
                    if (cmd == CMD_FIND) begin
                        r.status = ST_FOUND;
                        r.name   = tbl_name[hit];
                    end else begin
                        r.status       = ST_DELETED;
                        tbl_valid[hit] = 1'b0;
                        tbl_key[hit]   = '0;
                        tbl_name[hit]  = '0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [NAME_W-1:0] got_v,
                                   input logic [NAME_W-1:0] want_v);
        $display("ERROR %s: got %h expected %h", what, got_v, want_v);
        err_count++;
    endtask

    // result checking and prediction at each accepted item
    always @(posedge i_clk) begin : monitor
        t_table_result got;
        t_table_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = t_status'(m_axis_tuser);
                got.slot   = m_axis_tdata[SLOT_W-1:0];
                got.name   = m_axis_tdata[SLOT_W +: NAME_W];
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", got.name, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", NAME_W'(got.status),
                                        NAME_W'(want.status));
                    if (got.slot != want.slot)
                        report_mismatch("slot_index", NAME_W'(got.slot),
                                        NAME_W'(want.slot));
                    if (got.name != want.name)
                        report_mismatch("found_name", got.name, want.name);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_table_op(s_axis_tuser, s_axis_tdata[KEY_W-1:0],
                                      s_axis_tdata[KEY_W +: NAME_W]);
                pending_results.push_back(want);
            end
        end
    end

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("hash_table_linear_probe_replace: mismatch");
            $finish;
        end
    end

    // Returns right after the edge at which the item was taken.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [NAME_W-1:0] name);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_W - KEY_W - NAME_W){1'b0}}, name, key};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [NAME_W-1:0] rand_name();
        return {$urandom(), $urandom()};
    endfunction

    // home hits, displacement of an away resident, wrapped probe, duplicates
    task automatic test_insert_placement();
        send_item(CMD_INSERT, 34'd0, '0);
        send_item(CMD_INSERT, 34'd16, '1);                // home 0 taken by its owner
        send_item(CMD_INSERT, 34'd1, rand_name());        // displaces key 16
        send_item(CMD_INSERT, 34'd15, rand_name());
        send_item(CMD_INSERT, 34'd31, rand_name());       // probe wraps past last slot
        send_item(CMD_INSERT, '1, rand_name());           // widest key
        send_item(CMD_INSERT, 34'd9999999999, rand_name());
        send_item(CMD_INSERT, 34'd1, rand_name());        // duplicate key
    endtask

    task automatic test_find_delete();
        send_item(CMD_FIND, 34'd1, rand_name());
        send_item(CMD_FIND, 34'd16, '1);
        send_item(CMD_FIND, 34'd12345, '0);
        send_item(CMD_DELETE, 34'd1, rand_name());
        send_item(CMD_FIND, 34'd1, rand_name());          // duplicate now first match
        send_item(CMD_DELETE, 34'd777, rand_name());
        send_item(CMD_UNUSED, 34'd15, rand_name());
    endtask

    // nine slots are free here; the tenth insert finds the table full
    task automatic test_fill_to_full();
        repeat (10)
            send_item(CMD_INSERT, KEY_W'({$urandom(), $urandom()}), rand_name());
    endtask

    task automatic test_random_ops(input int n_items, input int idle_pct, input int stall_pct);
        logic [KEY_W-1:0]   key_pool [POOL_SIZE];
        logic [SLOT_W-1:0]  hot_home [4];
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        int                 insert_w;
        int                 pick;
        sender_idle_pct = idle_pct;
        rcv_stall_pct   = stall_pct;
        insert_w        = 45;
        foreach (hot_home[i])
            hot_home[i] = SLOT_W'($urandom());
        // half the pool shares a few homes so that probe chains build up
        foreach (key_pool[i]) begin
            key_pool[i] = KEY_W'({$urandom(), $urandom()});
            if (i < POOL_SIZE / 2)
                key_pool[i][SLOT_W-1:0] = hot_home[$urandom_range(3)];
        end
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0)
                insert_w = $urandom_range(20, 70);
            pick = $urandom_range(99);
            if (pick < 4)
                cmd = CMD_UNUSED;
            else if (pick < 4 + insert_w)
                cmd = CMD_INSERT;
            else if (pick % 2 == 0)
                cmd = CMD_FIND;
            else
                cmd = CMD_DELETE;
            if ($urandom_range(9) == 0)
                key = KEY_W'({$urandom(), $urandom()});
            else
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            send_item(cmd, key, rand_name());
        end
    endtask

    initial begin
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_name[i]  = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_insert_placement();
        test_find_delete();
        test_fill_to_full();
        test_random_ops(480, 0, 0);
        test_random_ops(480, 84, 0);
        test_random_ops(480, 0, 84);
        test_random_ops(480, 26, 26);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_count == 0)
            $display("hash_table_linear_probe_replace: match");
        else
            $display("hash_table_linear_probe_replace: mismatch");
        $finish;
    end

endmodule
